>>> rtl/twodom_pkg.sv
`default_nettype none
package twodom_pkg;

	localparam int CORDIC_STAGES      = 24;
	localparam int POSITION_FRAC_BITS = 16;
	localparam int CORDIC_ITERS       = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int POS_SHIFT          = 24 - POSITION_FRAC_BITS;

	localparam int CFG_W   = 24;
	localparam int CIDX_W  = 8;
	localparam int QUO_W   = 30;
	localparam int DEN_W   = 25;
	localparam int NUM_W   = 56;
	localparam int CNT_W   = 5;

	localparam logic [CIDX_W-1:0] REG_DIST_PER_COUNT = 8'd0;
	localparam logic [CIDX_W-1:0] REG_LEFT_OFFSET    = 8'd1;
	localparam logic [CIDX_W-1:0] REG_RIGHT_OFFSET   = 8'd2;
	localparam logic [CIDX_W-1:0] REG_REAR_OFFSET    = 8'd3;

	localparam logic [CFG_W-1:0] RST_DIST_PER_COUNT = 24'd466678;
	localparam logic [CFG_W-1:0] RST_LEFT_OFFSET    = 24'd297984;
	localparam logic [CFG_W-1:0] RST_RIGHT_OFFSET   = 24'd302080;
	localparam logic [CFG_W-1:0] RST_REAR_OFFSET    = 24'd294912;

	localparam logic [29:0] TQ_LIMIT   = 30'd843314856;
	localparam logic [31:0] RAD_TO_BAM = 32'd2734261102;
	localparam logic [31:0] INV_GAIN   = 32'd652032874;
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [31:0] CENTI_TURN = 32'd36000;

	localparam logic [31:0] ATAN_BAM [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	localparam logic [7:0] SERIES_DIV [7] = '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	// Each entry is floor(2^32 / SERIES_DIV); the estimate it gives is at most one too small.
	localparam logic [31:0] SERIES_RECIP [7] = '{
		32'd20452225, 32'd27531841, 32'd39045157, 32'd59652323, 32'd102261126,
		32'd214748364, 32'd715827882
	};

	typedef enum logic [4:0] {
		ST_IDLE, ST_DMUL, ST_DWB, ST_DIVSET, ST_TQWAIT, ST_BMUL, ST_BWB, ST_HMUL,
		ST_HWB, ST_SMUL, ST_SRMUL, ST_SQMUL, ST_SWB, ST_OMUL, ST_OWB, ST_MLO, ST_MHI,
		ST_MWB, ST_ROT, ST_CORD, ST_FIN, ST_HDMUL, ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
	} div_req_t;

endpackage
`default_nettype wire

>>> rtl/twodom_div.sv
`default_nettype none
module twodom_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  twodom_pkg::div_req_t         req,
	output logic                         done,
	output logic [twodom_pkg::QUO_W-1:0] quo
);
	import twodom_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W+1:0] trial;
	logic [DEN_W+1:0] sub;
	logic             ge;

	assign trial = {rem_q, num_q[QUO_W-1]};
	assign ge    = trial >= {2'b00, den_q};
	assign sub   = trial - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:QUO_W];
			num_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DEN_W:0] : trial[DEN_W:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			num_q <= {num_q[QUO_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < {1'b0, den_q}) else $error("divider remainder out of range");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not start");

endmodule
`default_nettype wire

>>> rtl/tracking_wheel_odometry.sv
`default_nettype none
// Three-wheel odometry: each beat on the input carries the cumulative left, right and side
// encoder counts, and one beat with global x, y (Q16.16 inches, wrapping) and the heading in
// hundredths of a degree comes out for each. The block works on one beat at a time with one
// 32 by 32 bit multiplier, a restoring divider for the heading change and a single CORDIC
// stage used iteratively; the chord factor series divides by its constant terms through
// reciprocal multiplication. The divider is skipped when the heading change needs no division
// (zero track width or a saturated turn). A result that is not taken holds the block once the
// next item is done.
module tracking_wheel_odometry (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [95:0]                        s_tdata,  // left_count, right_count, side_count
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [79:0]                        m_tdata,  // x_position, y_position, heading_centidegrees
	input  wire                                cfg_we,
	input  wire  [twodom_pkg::CIDX_W-1:0]      cfg_index,
	input  wire  [twodom_pkg::CFG_W-1:0]       cfg_data
);
	import twodom_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0] dpc_q, loff_q, roff_q, rear_q;
	logic [31:0] last_l_q, last_r_q, last_s_q, cin_l_q, cin_r_q, cin_s_q;
	logic [31:0] heading_q, pos_x_q, pos_y_q;
	logic signed [63:0] dl_q, dr_q, ds_q, vx_q, vy_q;
	logic        sgn_q, tq_neg_q, phase_q;
	logic [29:0] tq_mag_q;
	logic signed [32:0] dbam_q;
	logic [31:0] h2_q;
	logic [30:0] c_q;
	logic [2:0]  sidx_q;
	logic [31:0] sn_q, sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [33:0] z_q;
	logic [33:0] plo_q;
	logic [63:0] prod_q;
	logic        out_valid_q;
	logic [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;

	logic [31:0] mul_a, mul_b;
	div_req_t    div_req;
	logic        div_done;
	logic [QUO_W-1:0] div_quo;

	logic [31:0] chg, d_mag;
	logic        d_neg;
	logic signed [63:0] diff, vsel;
	logic [63:0] diff_mag, m_mag, mq_res;
	logic [DEN_W-1:0] wid;
	logic        tq_sat, tq_zero;
	logic [31:0] kmul;
	logic [63:0] bm_sum;
	logic signed [63:0] off_s, off_sh;
	logic [31:0] mid, ang, zang;
	logic [1:0]  quad;
	logic signed [63:0] xsh, ysh, fx, fy;
	logic [31:0] s_rem, s_quo;

	twodom_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    chg = cin_l_q - last_l_q;
			2'd1:    chg = cin_r_q - last_r_q;
			default: chg = cin_s_q - last_s_q;
		endcase
		d_mag = chg[31] ? (~chg + 32'd1) : chg;
		d_neg = (chg != 32'd0) && !chg[31];

		diff     = dl_q - dr_q;
		diff_mag = diff[63] ? 64'(-diff) : 64'(diff);
		wid      = {1'b0, loff_q} + {1'b0, roff_q};
		tq_zero  = (wid == '0);
		tq_sat   = (diff_mag[63:42] != '0) || (diff_mag[41:0] >= {7'd0, wid, 10'd0});

		vsel   = cnt_q[0] ? vy_q : vx_q;
		m_mag  = vsel[63] ? 64'(-vsel) : 64'(vsel);
		kmul   = phase_q ? INV_GAIN : {1'b0, c_q};
		mq_res = {prod_q[61:0], 2'b00} + {30'd0, plo_q};

		bm_sum = prod_q + 64'h2000_0000;
		off_s  = tq_neg_q ? -$signed(prod_q) : $signed(prod_q);
		off_sh = off_s >>> 20;

		mid  = heading_q + dbam_q[32:1];
		ang  = 32'd0 - mid;
		quad = 2'(ang + 32'h2000_0000 >> 30);
		zang = ang - {quad, 30'd0};

		xsh = vx_q >>> cnt_q;
		ysh = vy_q >>> cnt_q;
		fx  = vx_q >>> POS_SHIFT;
		fy  = vy_q >>> POS_SHIFT;

		s_rem = sn_q - prod_q[31:0];
		s_quo = (s_rem >= {24'd0, SERIES_DIV[sidx_q]}) ? sq_q + 32'd1 : sq_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_DMUL;
			ST_DMUL:   state_d = ST_DWB;
			ST_DWB:    state_d = (cnt_q == CNT_W'(2)) ? ST_DIVSET : ST_DMUL;
			ST_DIVSET: state_d = (tq_zero || tq_sat) ? ST_BMUL : ST_TQWAIT;
			ST_TQWAIT: if (div_done) state_d = ST_BMUL;
			ST_BMUL:   state_d = ST_BWB;
			ST_BWB:    state_d = ST_HMUL;
			ST_HMUL:   state_d = ST_HWB;
			ST_HWB:    state_d = ST_SMUL;
			ST_SMUL:   state_d = ST_SRMUL;
			ST_SRMUL:  state_d = ST_SQMUL;
			ST_SQMUL:  state_d = ST_SWB;
			ST_SWB:    state_d = (sidx_q == 3'd6) ? ST_OMUL : ST_SMUL;
			ST_OMUL:   state_d = ST_OWB;
			ST_OWB:    state_d = (cnt_q == CNT_W'(1)) ? ST_MLO : ST_OMUL;
			ST_MLO:    state_d = ST_MHI;
			ST_MHI:    state_d = ST_MWB;
			ST_MWB: begin
				if (cnt_q == '0) state_d = ST_MLO;
				else state_d = phase_q ? ST_FIN : ST_ROT;
			end
			ST_ROT:    state_d = ST_CORD;
			ST_CORD:   if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) state_d = ST_MLO;
			ST_FIN:    state_d = ST_HDMUL;
			ST_HDMUL:  state_d = ST_OUT;
			ST_OUT:    if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		mul_a       = heading_q;
		mul_b       = CENTI_TURN;
		div_req.start = 1'b0;
		div_req.num   = {diff_mag[35:0], 20'd0};
		div_req.den   = wid;
		unique case (state_q)
			ST_DMUL: begin
				mul_a = d_mag;
				mul_b = {8'd0, dpc_q};
			end
			ST_DIVSET: div_req.start = !(tq_zero || tq_sat);
			ST_BMUL: begin
				mul_a = {2'b00, tq_mag_q};
				mul_b = RAD_TO_BAM;
			end
			ST_HMUL: begin
				mul_a = {2'b00, tq_mag_q};
				mul_b = {2'b00, tq_mag_q};
			end
			ST_SMUL: begin
				mul_a = h2_q;
				mul_b = {1'b0, c_q};
			end
			ST_SRMUL: begin
				mul_a = prod_q[61:30];
				mul_b = SERIES_RECIP[sidx_q];
			end
			ST_SQMUL: begin
				mul_a = prod_q[63:32];
				mul_b = {24'd0, SERIES_DIV[sidx_q]};
			end
			ST_OMUL: begin
				mul_a = {8'd0, cnt_q[0] ? roff_q : rear_q};
				mul_b = {2'b00, tq_mag_q};
			end
			ST_MLO: begin
				mul_a = m_mag[31:0];
				mul_b = kmul;
			end
			ST_MHI: begin
				mul_a = m_mag[63:32];
				mul_b = kmul;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dpc_q       <= RST_DIST_PER_COUNT;
			loff_q      <= RST_LEFT_OFFSET;
			roff_q      <= RST_RIGHT_OFFSET;
			rear_q      <= RST_REAR_OFFSET;
			last_l_q    <= '0;
			last_r_q    <= '0;
			last_s_q    <= '0;
			heading_q   <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			sidx_q      <= '0;
			phase_q     <= 1'b0;
			c_q         <= ONE_Q30;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIST_PER_COUNT: dpc_q  <= cfg_data;
					REG_LEFT_OFFSET:    loff_q <= cfg_data;
					REG_RIGHT_OFFSET:   roff_q <= cfg_data;
					REG_REAR_OFFSET:    rear_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == ST_OUT) && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					phase_q <= 1'b0;
				end
				ST_DWB: cnt_q <= (cnt_q == CNT_W'(2)) ? '0 : cnt_q + 1'b1;
				ST_HWB: begin
					c_q    <= ONE_Q30;
					sidx_q <= '0;
				end
				ST_SWB: begin
					c_q    <= ONE_Q30 - s_quo[30:0];
					sidx_q <= sidx_q + 3'd1;
				end
				ST_OWB: cnt_q <= (cnt_q == CNT_W'(1)) ? '0 : cnt_q + 1'b1;
				ST_MWB: cnt_q <= (cnt_q == '0) ? CNT_W'(1) : '0;
				ST_ROT: cnt_q <= '0;
				ST_CORD: begin
					if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) begin
						cnt_q   <= '0;
						phase_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					pos_x_q   <= pos_x_q + fx[31:0];
					pos_y_q   <= pos_y_q + fy[31:0];
					heading_q <= heading_q + dbam_q[31:0];
					last_l_q  <= cin_l_q;
					last_r_q  <= cin_r_q;
					last_s_q  <= cin_s_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			ST_IDLE: begin
				cin_l_q <= s_tdata[31:0];
				cin_r_q <= s_tdata[63:32];
				cin_s_q <= s_tdata[95:64];
			end
			ST_DMUL: sgn_q <= d_neg;
			ST_DWB: begin
				unique case (cnt_q[1:0])
					2'd0:    dl_q <= sgn_q ? -$signed(prod_q) : $signed(prod_q);
					2'd1:    dr_q <= sgn_q ? -$signed(prod_q) : $signed(prod_q);
					default: ds_q <= sgn_q ? -$signed(prod_q) : $signed(prod_q);
				endcase
			end
			ST_DIVSET: begin
				tq_neg_q <= diff[63];
				tq_mag_q <= tq_zero ? '0 : TQ_LIMIT;
			end
			ST_TQWAIT: begin
				if (div_done) tq_mag_q <= (div_quo > TQ_LIMIT) ? TQ_LIMIT : div_quo;
			end
			ST_BWB: dbam_q <= tq_neg_q ? -$signed({1'b0, bm_sum[61:30]})
				: $signed({1'b0, bm_sum[61:30]});
			ST_HWB: h2_q <= prod_q[59:28];
			ST_SRMUL: sn_q <= prod_q[61:30];
			ST_SQMUL: sq_q <= prod_q[63:32];
			ST_OWB: begin
				if (cnt_q[0]) vy_q <= dr_q + off_sh;
				else vx_q <= ds_q + off_sh;
			end
			ST_MHI: plo_q <= prod_q[63:30];
			ST_MWB: begin
				if (cnt_q[0]) vy_q <= vy_q[63] ? -$signed(mq_res) : $signed(mq_res);
				else vx_q <= vx_q[63] ? -$signed(mq_res) : $signed(mq_res);
			end
			ST_ROT: begin
				z_q <= 34'($signed(zang));
				unique case (quad)
					2'd1: begin
						vx_q <= -vy_q;
						vy_q <= vx_q;
					end
					2'd2: begin
						vx_q <= -vx_q;
						vy_q <= -vy_q;
					end
					2'd3: begin
						vx_q <= vy_q;
						vy_q <= -vx_q;
					end
					default: ;
				endcase
			end
			ST_CORD: begin
				if (!z_q[33]) begin
					vx_q <= vx_q - ysh;
					vy_q <= vy_q + xsh;
					z_q  <= z_q - $signed({2'b00, ATAN_BAM[cnt_q]});
				end else begin
					vx_q <= vx_q + ysh;
					vy_q <= vy_q - xsh;
					z_q  <= z_q + $signed({2'b00, ATAN_BAM[cnt_q]});
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_x_q <= pos_x_q;
					out_y_q <= pos_y_q;
					out_h_q <= prod_q[47:32];
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_h_q, out_y_q, out_x_q};

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_h_q < 16'd36000) else $error("heading out of range");
	a_chord_bound: assert property (@(posedge clk) disable iff (!arst_n)
		c_q <= ONE_Q30) else $error("chord factor above one");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import twodom_pkg::*;

	localparam logic [CIDX_W-1:0] REG_UNMAPPED = 8'd200;

	typedef struct {
		logic signed [31:0] left;
		logic signed [31:0] right;
		logic signed [31:0] side;
	} counts_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] heading;
	} pose_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [95:0]        s_tdata;   // left_count, right_count, side_count
	logic               m_tvalid;
	logic               m_tready;
	logic [79:0]        m_tdata;   // x_position, y_position, heading_centidegrees
	logic               cfg_we;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	counts_t     pending_counts[$];
	pose_t       expected_poses[$];
	counts_t     offered;
	pose_t       predicted;
	pose_t       wanted;
	bit          calm;
	int          errors = 0;
	int          driver_gap;
	int          reader_gap;
	int          reader_hold;
	int          poses_seen;

	bit [23:0]   dist_per_count;
	bit [23:0]   left_offset;
	bit [23:0]   right_offset;
	bit [23:0]   rear_offset;
	logic [31:0] prev_left, prev_right, prev_side;
	logic [31:0] heading_bam, pos_x, pos_y;
	logic [31:0] gen_left, gen_right, gen_side;

	tracking_wheel_odometry dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#25ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint scale_q30(input longint a, input bit [63:0] k);
		bit [63:0] m;
		bit [63:0] r;
		if (a < 0) m = 64'd0 - a;
		else m = a;
		r = (((m >> 32) * k) << 2) + (((m & 64'hFFFF_FFFF) * k) >> 30);
		if (a < 0) return -longint'(r);
		return longint'(r);
	endfunction

	function automatic pose_t advance_odometry(input counts_t c);
		pose_t     p;
		int        chg;
		longint    dpc, dl, dr, ds, diff, tq, dbam, xs, ys, x, y, t, z, xsh, ysh;
		bit [63:0] width, mag, qv, tm, h2, cf, bm;
		bit [31:0] mid, ang, quad;
		dpc = longint'(dist_per_count);
		chg = c.left - prev_left;
		dl = -longint'(chg) * dpc;
		chg = c.right - prev_right;
		dr = -longint'(chg) * dpc;
		chg = c.side - prev_side;
		ds = -longint'(chg) * dpc;
		diff = dl - dr;
		tq = 0;
		width = 64'(left_offset) + 64'(right_offset);
		if (width != 0) begin
			if (diff < 0) mag = 64'd0 - diff;
			else mag = diff;
			if (mag >= (64'd1 << 42)) qv = 64'(TQ_LIMIT);
			else qv = (mag << 20) / width;
			if (qv > 64'(TQ_LIMIT)) qv = 64'(TQ_LIMIT);
			if (diff < 0) tq = -longint'(qv);
			else tq = longint'(qv);
		end
		if (tq < 0) tm = 64'd0 - tq;
		else tm = tq;
		bm = (tm * 64'(RAD_TO_BAM) + (64'd1 << 29)) >> 30;
		if (tq < 0) dbam = -longint'(bm);
		else dbam = longint'(bm);
		h2 = (tm * tm) >> 28;
		cf = 64'd1 << 30;
		for (int i = 0; i < 7; i++)
			cf = (64'd1 << 30) - ((h2 * cf / 64'(SERIES_DIV[i])) >> 30);
		xs = ds + ((longint'(rear_offset) * tq) >>> 20);
		ys = dr + ((longint'(right_offset) * tq) >>> 20);
		x = scale_q30(xs, cf);
		y = scale_q30(ys, cf);
		mid = heading_bam + 32'(dbam >>> 1);
		ang = 32'd0 - mid;
		quad = (ang + 32'h2000_0000) >> 30;
		z = longint'(int'(ang - (quad << 30)));
		if (quad == 1) begin
			t = x; x = -y; y = t;
		end else if (quad == 2) begin
			x = -x; y = -y;
		end else if (quad == 3) begin
			t = x; x = y; y = -t;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xsh = x >>> i;
			ysh = y >>> i;
			if (z >= 0) begin
				x = x - ysh; y = y + xsh; z = z - longint'(ATAN_BAM[i]);
			end else begin
				x = x + ysh; y = y - xsh; z = z + longint'(ATAN_BAM[i]);
			end
		end
		x = scale_q30(x, 64'(INV_GAIN));
		y = scale_q30(y, 64'(INV_GAIN));
		pos_x = pos_x + 32'(x >>> POS_SHIFT);
		pos_y = pos_y + 32'(y >>> POS_SHIFT);
		heading_bam = heading_bam + 32'(dbam);
		prev_left = c.left;
		prev_right = c.right;
		prev_side = c.side;
		p.x = pos_x;
		p.y = pos_y;
		p.heading = 16'((64'(heading_bam) * 64'(CENTI_TURN)) >> 32);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			driver_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = advance_odometry(offered);
				expected_poses.push_back(predicted);
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (driver_gap != 0) begin
				s_tvalid <= 1'b0;
				driver_gap = driver_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				driver_gap = $urandom_range(0, 16);
			end else if (pending_counts.size() != 0) begin
				offered = pending_counts.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {offered.side, offered.right, offered.left};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			reader_gap = 0;
			reader_hold = 0;
			poses_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				poses_seen = poses_seen + 1;
				if (poses_seen == 50) reader_hold = 3000;
				if (expected_poses.size() == 0) begin
					$error("unexpected output beat %h", m_tdata);
					errors = errors + 1;
				end else begin
					wanted = expected_poses.pop_front();
					if (m_tdata[31:0] !== wanted.x) begin
						$error("x_position: expected %0d, got %0d",
							$signed(wanted.x), $signed(m_tdata[31:0]));
						errors = errors + 1;
					end
					if (m_tdata[63:32] !== wanted.y) begin
						$error("y_position: expected %0d, got %0d",
							$signed(wanted.y), $signed(m_tdata[63:32]));
						errors = errors + 1;
					end
					if (m_tdata[79:64] !== wanted.heading) begin
						$error("heading_centidegrees: expected %0d, got %0d",
							wanted.heading, m_tdata[79:64]);
						errors = errors + 1;
					end
				end
			end
			if (reader_hold != 0) begin
				m_tready <= 1'b0;
				reader_hold = reader_hold - 1;
			end else if (reader_gap != 0) begin
				m_tready <= 1'b0;
				reader_gap = reader_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				reader_gap = $urandom_range(0, 16);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_counts(input logic [31:0] l, input logic [31:0] r, input logic [31:0] s);
		counts_t c;
		c.left = l;
		c.right = r;
		c.side = s;
		pending_counts.push_back(c);
		gen_left = l;
		gen_right = r;
		gen_side = s;
	endtask

	function automatic logic [31:0] wander(input logic [31:0] base);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) return base + $urandom_range(0, 400) - 200;
		if (pick < 92) return base + $urandom_range(0, 200000) - 100000;
		return $urandom;
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_counts(wander(gen_left), wander(gen_right), wander(gen_side));
	endtask

	task automatic drain;
		while (pending_counts.size() != 0 || s_tvalid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_DIST_PER_COUNT: dist_per_count = value;
			REG_LEFT_OFFSET:    left_offset = value;
			REG_RIGHT_OFFSET:   right_offset = value;
			REG_REAR_OFFSET:    rear_offset = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		dist_per_count = RST_DIST_PER_COUNT;
		left_offset = RST_LEFT_OFFSET;
		right_offset = RST_RIGHT_OFFSET;
		rear_offset = RST_REAR_OFFSET;
		prev_left = '0; prev_right = '0; prev_side = '0;
		heading_bam = '0; pos_x = '0; pos_y = '0;
		gen_left = '0; gen_right = '0; gen_side = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_counts(32'd0, 32'd0, 32'd0);
		send_counts(32'd100, 32'd100, 32'd100);
		send_counts(32'd5100, -32'd4900, 32'd100);
		send_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_counts(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_counts(32'd1000000, -32'd1000000, 32'd0);
		send_counts(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		send_counts(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		send_counts(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		send_counts(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
		send_random(600);
		drain();

		write_reg(REG_LEFT_OFFSET, 24'd0);
		write_reg(REG_RIGHT_OFFSET, 24'd0);
		write_reg(REG_REAR_OFFSET, 24'hFF_FFFF);
		send_counts(gen_left + 32'd5000, gen_right - 32'd5000, gen_side + 32'd7);
		send_random(100);
		drain();

		write_reg(REG_DIST_PER_COUNT, 24'd1);
		write_reg(REG_LEFT_OFFSET, 24'hFF_FFFF);
		write_reg(REG_RIGHT_OFFSET, 24'hFF_FFFF);
		write_reg(REG_REAR_OFFSET, 24'd0);
		send_counts(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_random(150);
		drain();

		write_reg(REG_DIST_PER_COUNT, 24'hFF_FFFF);
		write_reg(REG_LEFT_OFFSET, 24'd1);
		write_reg(REG_RIGHT_OFFSET, 24'd0);
		write_reg(REG_UNMAPPED, 24'h12_3456);
		send_random(150);
		drain();

		write_reg(REG_DIST_PER_COUNT, RST_DIST_PER_COUNT);
		write_reg(REG_LEFT_OFFSET, RST_LEFT_OFFSET);
		write_reg(REG_RIGHT_OFFSET, RST_RIGHT_OFFSET);
		write_reg(REG_REAR_OFFSET, RST_REAR_OFFSET);
		send_random(100);
		while (pending_counts.size() > 50) @(posedge clk);
		calm = 1'b1;
		send_random(150);
		drain();
		repeat (400) @(posedge clk);

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
